### design/two_channel_pulse_id_detector_top_defines.svh
// ----------------------------------------------------------------------------
// Pulse ID detector assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_PULSE_ID_DETECTOR_TOP_DEFINES_SVH
`define TWO_CHANNEL_PULSE_ID_DETECTOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TCPID_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse id detector check failed");

// next-cycle implication
`define TCPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse id detector check failed");

`else

`define TCPID_ASSERT_NOW(label, clk, rst, ante, cons)
`define TCPID_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/tcpid_pkg.sv
// ----------------------------------------------------------------------------
// Pulse ID detector package
// Codes, width thresholds and shared types of the two-channel ID detector.
// ----------------------------------------------------------------------------
package tcpid_pkg;

  localparam int DEF_COUNT_BITS = 24;
  localparam int TIMEOUT_BITS   = 24;
  localparam int WIDE_BITS      = 32;
  localparam int STATUS_BITS    = 2;
  localparam int IDENT_BITS     = 6;
  localparam int TABLE_LEN      = 36;
  localparam int ID_STEPS       = 36;
  localparam int BOUND_BITS     = 17;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(13500000);
  localparam logic [WIDE_BITS-1:0]    MIN_WIDTH     = WIDE_BITS'(5);

  // command kinds carried on the input tuser bit
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE      = 2'd0,
    ST_TIMEOUT   = 2'd1,
    ST_NO_ANSWER = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_WAIT_RISE = 5'b00001,
    PH_WAIT_FALL = 5'b00010,
    PH_DONE      = 5'b00100,
    PH_TIMEOUT   = 5'b01000,
    PH_NO_ANSWER = 5'b10000
  } phase_t;

  // upper bound of each ID step, exclusive
  localparam logic [BOUND_BITS-1:0] UPPER_BOUND [TABLE_LEN] = '{
    17'd110,   17'd135,   17'd165,   17'd200,   17'd245,   17'd300,
    17'd360,   17'd430,   17'd515,   17'd620,   17'd750,   17'd910,
    17'd1100,  17'd1350,  17'd1650,  17'd2000,  17'd2450,  17'd3000,
    17'd3600,  17'd4300,  17'd5150,  17'd6200,  17'd7500,  17'd9100,
    17'd11000, 17'd13500, 17'd16500, 17'd20000, 17'd24500, 17'd30000,
    17'd36000, 17'd43000, 17'd51500, 17'd62000, 17'd75000, 17'd91000
  };

  typedef struct packed {
    logic sample;   // an item is processed: take the line level
    logic start;    // start command
    logic step;     // tick while a scan runs
    logic timeout;  // counter reached the timeout on this tick
  } chan_ctrl_t;

  typedef struct packed {
    logic                  finished;
    status_t               status;
    logic [IDENT_BITS-1:0] ident;
  } chan_stat_t;

  // map a pulse width to an ID, 0 when outside the table
  function automatic logic [IDENT_BITS-1:0] width_to_id(input logic [WIDE_BITS-1:0] w);
    logic [IDENT_BITS-1:0] id;
    logic                  found;
    id    = '0;
    found = 1'b0;
    if (w >= MIN_WIDTH) begin
      for (int i = 0; i < TABLE_LEN; i++) begin
        if (!found && (i < ID_STEPS) && (w < WIDE_BITS'(UPPER_BOUND[i]))) begin
          id    = IDENT_BITS'(i + 1);
          found = 1'b1;
        end
      end
    end
    return id;
  endfunction

endpackage

### design/tcpid_chan.sv
// ----------------------------------------------------------------------------
// Pulse ID channel
// Edge detection, pulse timing and ID decode for one ID line.
// ----------------------------------------------------------------------------
`include "two_channel_pulse_id_detector_top_defines.svh"

module tcpid_chan #(
  parameter int COUNT_BITS = tcpid_pkg::DEF_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tcpid_pkg::chan_ctrl_t  ctrl,
  input  logic [COUNT_BITS-1:0]  tick_next,
  input  logic                   level,
  output tcpid_pkg::chan_stat_t  stat
);
  import tcpid_pkg::*;

  phase_t                phase;
  phase_t                phase_next;
  phase_t                phase_edge;
  logic                  last_level;
  logic [COUNT_BITS-1:0] rise_time;
  logic [COUNT_BITS-1:0] pulse_width;
  logic [COUNT_BITS-1:0] width_next;
  logic                  rise;
  logic                  fall;
  logic [IDENT_BITS-1:0] id;

  assign rise = ctrl.step && level && !last_level;
  assign fall = ctrl.step && !level && last_level && (phase == PH_WAIT_FALL);

  assign width_next = fall ? (tick_next - rise_time) : pulse_width;

  always_comb begin
    phase_edge = phase;
    if (rise) begin
      phase_edge = PH_WAIT_FALL;
    end else if (fall) begin
      phase_edge = PH_DONE;
    end
    phase_next = phase_edge;
    if (ctrl.start) begin
      phase_next = PH_WAIT_RISE;
    end else if (ctrl.step && ctrl.timeout) begin
      if (phase_edge == PH_WAIT_FALL) begin
        phase_next = PH_TIMEOUT;
      end else if (phase_edge == PH_WAIT_RISE) begin
        phase_next = PH_NO_ANSWER;
      end
    end
  end

  assign id = width_to_id(WIDE_BITS'(width_next));

  always_comb begin
    stat.finished = (phase_next != PH_WAIT_RISE) && (phase_next != PH_WAIT_FALL);
    stat.ident    = '0;
    unique case (phase_next)
      PH_DONE: begin
        stat.ident  = id;
        stat.status = (id != '0) ? ST_DONE : ST_INVALID;
      end
      PH_TIMEOUT: stat.status = ST_TIMEOUT;
      default:    stat.status = ST_NO_ANSWER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT_RISE;
      last_level <= 1'b0;
    end else if (ctrl.sample) begin
      phase      <= phase_next;
      last_level <= level;
    end
  end

  // timing stores need no reset
  always_ff @(posedge clk) begin
    if (rise) begin
      rise_time <= tick_next;
    end
    if (fall) begin
      pulse_width <= width_next;
    end
  end

  `TCPID_ASSERT_NEXT(a_start_rearms, clk, rst, ctrl.sample && ctrl.start, phase == PH_WAIT_RISE)
  `TCPID_ASSERT_NOW(a_timeout_ends, clk, rst, ctrl.step && ctrl.timeout && !ctrl.start,
    stat.finished)
  `TCPID_ASSERT_NEXT(a_rise_waits, clk, rst, rise && !ctrl.start,
    (phase == PH_WAIT_FALL) || (phase == PH_TIMEOUT))

endmodule

### design/two_channel_pulse_id_detector_top.sv
// A result beat leaves once its input beat is taken and has passed the input
// register, then the result register.
// Throughput: one input beat per cycle, held only while the result side stalls.
// Each input beat gives exactly one result beat.
// Reset: synchronous; no scan runs, both channels wait for a rise, the timeout
// register returns to 13500000 ticks and both pipeline registers are empty.
// ----------------------------------------------------------------------------
// Two-channel pulse ID detector
// Times the ID pulses of two boards against a tick counter and decodes IDs.
// ----------------------------------------------------------------------------
`include "two_channel_pulse_id_detector_top_defines.svh"

module two_channel_pulse_id_detector_top #(
  parameter int COUNT_BITS = tcpid_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tcpid_pkg::TIMEOUT_BITS-1:0]  cfg_wr_data,   // timeout_ticks
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // line_one_level, line_two_level
  input  logic [0:0]                          s_axis_tuser,  // command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // id_clock_high, scan_done, chan_one_status, chan_one_ident,
  // chan_two_status, chan_two_ident
  output logic [23:0]                         m_axis_tdata
);
  import tcpid_pkg::*;

  logic [TIMEOUT_BITS-1:0] timeout_ticks;

  logic                    in_valid;
  logic                    in_command;
  logic                    in_line_one;
  logic                    in_line_two;
  logic                    advance;

  logic                    scanning;
  logic                    scanning_next;
  logic [COUNT_BITS-1:0]   tick_count;
  logic [COUNT_BITS-1:0]   tick_next;
  logic                    timeout_hit;
  logic                    is_start;
  logic                    done;
  logic                    clock_high;
  chan_ctrl_t              ctrl;
  chan_stat_t              stat_one;
  chan_stat_t              stat_two;

  logic                    out_valid;
  logic [23:0]             out_data;
  logic [23:0]             out_data_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  // input register
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_command  <= s_axis_tuser[0];
      in_line_one <= s_axis_tdata[0];
      in_line_two <= s_axis_tdata[1];
    end
  end

  // counter saturates at all ones
  assign is_start    = (in_command == CMD_START);
  assign tick_next   = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign timeout_hit = (WIDE_BITS'(tick_next) >= WIDE_BITS'(timeout_ticks)) ||
                       (tick_next == '1);

  assign ctrl.sample  = advance;
  assign ctrl.start   = advance && is_start;
  assign ctrl.step    = advance && !is_start && scanning;
  assign ctrl.timeout = timeout_hit;

  tcpid_chan #(.COUNT_BITS(COUNT_BITS)) u_chan_one (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .tick_next (tick_next),
    .level     (in_line_one),
    .stat      (stat_one)
  );

  tcpid_chan #(.COUNT_BITS(COUNT_BITS)) u_chan_two (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .tick_next (tick_next),
    .level     (in_line_two),
    .stat      (stat_two)
  );

  assign done = ctrl.step && stat_one.finished && stat_two.finished;

  always_comb begin
    scanning_next = scanning;
    if (ctrl.start) begin
      scanning_next = 1'b1;
    end else if (done) begin
      scanning_next = 1'b0;
    end
  end

  assign clock_high = is_start || (scanning && !done);

  always_comb begin
    out_data_next        = '0;
    out_data_next[0]     = clock_high;
    out_data_next[1]     = done;
    if (done) begin
      out_data_next[3:2]   = stat_one.status;
      out_data_next[9:4]   = stat_one.ident;
      out_data_next[11:10] = stat_two.status;
      out_data_next[17:12] = stat_two.ident;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      tick_count <= '0;
    end else if (ctrl.start) begin
      scanning   <= 1'b1;
      tick_count <= '0;
    end else if (ctrl.step) begin
      scanning   <= scanning_next;
      tick_count <= tick_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `TCPID_ASSERT_NOW(a_done_drops_clock, clk, rst, m_axis_tvalid && m_axis_tdata[1],
    !m_axis_tdata[0])
  `TCPID_ASSERT_NEXT(a_start_clears_count, clk, rst, ctrl.start, scanning && (tick_count == '0))
  `TCPID_ASSERT_NEXT(a_idle_count_holds, clk, rst, !scanning && !ctrl.start, $stable(tick_count))
  `TCPID_ASSERT_NOW(a_scan_ends_on_done, clk, rst, $fell(scanning), $past(done))

endmodule
